// ----- design/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and widths for the triangle unit normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

    localparam int COORD_W       = 32;
    localparam int EDGE_W        = COORD_W + 1;
    localparam int MAG_W         = 65;
    localparam int SUM_W         = 2 * MAG_W + 2;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int REM_W         = ROOT_W + 2;
    localparam int DREM_W        = ROOT_W + 1;
    localparam int QUOT_W        = 31;
    localparam int OUT_W         = 32;
    localparam int MID_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } tri_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    degenerate;
    } norm_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } vec_t;

    typedef struct packed {
        vec_t             vec;
        logic [SUM_W-1:0] sum;
    } cross_t;

endpackage

`default_nettype wire

// ----- design/tun_fifo.sv -----
// ----------------------------------------------------------------------------
// tun_fifo
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = store_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/tun_front.sv -----
// ----------------------------------------------------------------------------
// tun_front
// Edges, exact cross product and squared length, six pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire tun_pkg::tri_t vertices,
    output logic               out_valid,
    input  wire logic          out_full,
    output tun_pkg::cross_t    out_data
);

    import tun_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0]               valid_reg;
    logic                          adv;

    logic signed [EDGE_W-1:0]      u_reg [3];
    logic signed [EDGE_W-1:0]      v_reg [3];
    logic signed [EDGE_W-1:0]      u_next [3];
    logic signed [EDGE_W-1:0]      v_next [3];

    logic signed [EDGE_W-1:0]      opa [6];
    logic signed [EDGE_W-1:0]      opb [6];
    logic [2*COORD_W-1:0]          prod_reg [6];
    logic [2*COORD_W-1:0]          prod_next [6];
    logic [5:0]                    psign_reg;
    logic [5:0]                    psign_next;

    vec_t                          vec3_reg;
    vec_t                          vec3_next;
    vec_t                          vec4_reg;
    vec_t                          vec5_reg;
    vec_t                          vec6_reg;

    logic [2*(MAG_W-32)-1:0]       hh_reg [3];
    logic [MAG_W-1:0]              hl_reg [3];
    logic [63:0]                   ll_reg [3];
    logic [2*(MAG_W-32)-1:0]       hh_next [3];
    logic [MAG_W-1:0]              hl_next [3];
    logic [63:0]                   ll_next [3];

    logic [SUM_W-3:0]              sq_reg [3];
    logic [SUM_W-3:0]              sq_next [3];
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;

    function automatic logic [COORD_W-1:0] edge_mag(input logic signed [EDGE_W-1:0] e);
        logic [EDGE_W-1:0] t;
        t = e[EDGE_W-1] ? EDGE_W'(-e) : EDGE_W'(e);
        return t[COORD_W-1:0];
    endfunction

    assign adv       = !valid_reg[NSTG-1] || !out_full;
    assign full      = !adv;
    assign out_valid = valid_reg[NSTG-1];
    assign out_data  = '{vec: vec6_reg, sum: sum_reg};

    always_comb
    begin
        u_next[0] = EDGE_W'(vertices.ax) - EDGE_W'(vertices.bx);
        u_next[1] = EDGE_W'(vertices.ay) - EDGE_W'(vertices.by);
        u_next[2] = EDGE_W'(vertices.az) - EDGE_W'(vertices.bz);
        v_next[0] = EDGE_W'(vertices.bx) - EDGE_W'(vertices.cx);
        v_next[1] = EDGE_W'(vertices.by) - EDGE_W'(vertices.cy);
        v_next[2] = EDGE_W'(vertices.bz) - EDGE_W'(vertices.cz);
    end

    // term pairs: x = uy*vz - uz*vy, y = vx*uz - ux*vz, z = ux*vy - vx*uy
    always_comb
    begin
        opa[0] = u_reg[1]; opb[0] = v_reg[2];
        opa[1] = u_reg[2]; opb[1] = v_reg[1];
        opa[2] = v_reg[0]; opb[2] = u_reg[2];
        opa[3] = u_reg[0]; opb[3] = v_reg[2];
        opa[4] = u_reg[0]; opb[4] = v_reg[1];
        opa[5] = v_reg[0]; opb[5] = u_reg[1];
        for (int i = 0; i < 6; i++)
        begin
            prod_next[i]  = edge_mag(opa[i]) * edge_mag(opb[i]);
            psign_next[i] = opa[i][EDGE_W-1] ^ opb[i][EDGE_W-1];
        end
    end

    always_comb
    begin
        logic signed [MAG_W:0] ta;
        logic signed [MAG_W:0] tb;
        logic signed [MAG_W:0] n;
        logic [MAG_W:0]        m;
        vec3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            ta = psign_reg[2*i]   ? -(MAG_W+1)'(prod_reg[2*i])   : (MAG_W+1)'(prod_reg[2*i]);
            tb = psign_reg[2*i+1] ? -(MAG_W+1)'(prod_reg[2*i+1]) : (MAG_W+1)'(prod_reg[2*i+1]);
            n  = ta - tb;
            m  = n[MAG_W] ? (MAG_W+1)'(-n) : (MAG_W+1)'(n);
            vec3_next.mag[i] = m[MAG_W-1:0];
            vec3_next.neg[i] = n[MAG_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hh_next[i] = vec3_reg.mag[i][MAG_W-1:32] * vec3_reg.mag[i][MAG_W-1:32];
            hl_next[i] = vec3_reg.mag[i][MAG_W-1:32] * vec3_reg.mag[i][31:0];
            ll_next[i] = vec3_reg.mag[i][31:0] * vec3_reg.mag[i][31:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = ((SUM_W-2)'(hh_reg[i]) << 64) + ((SUM_W-2)'(hl_reg[i]) << 33)
                       + (SUM_W-2)'(ll_reg[i]);
        end
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg     <= u_next;
            v_reg     <= v_next;
            prod_reg  <= prod_next;
            psign_reg <= psign_next;
            vec3_reg  <= vec3_next;
            vec4_reg  <= vec3_reg;
            vec5_reg  <= vec4_reg;
            vec6_reg  <= vec5_reg;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            sq_reg    <= sq_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tun_back.sv -----
// ----------------------------------------------------------------------------
// tun_back
// Pipelined integer square root, three pipelined dividers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_take,
    input  wire tun_pkg::cross_t in_data,
    output logic                 empty,
    input  wire logic            pop,
    output tun_pkg::norm_t       normal
);

    import tun_pkg::*;

    logic                 adv;
    logic                 out_valid_reg;
    norm_t                out_reg;
    norm_t                out_next;

    logic [ROOT_W-1:0]    rt_valid_reg;
    logic [REM_W-1:0]     rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]    rt_root_reg [ROOT_W];
    logic [SUM_W-1:0]     rt_rest_reg [ROOT_W];
    vec_t                 rt_vec_reg  [ROOT_W];
    logic [REM_W-1:0]     rt_rem_in   [ROOT_W];
    logic [ROOT_W-1:0]    rt_root_in  [ROOT_W];
    logic [SUM_W-1:0]     rt_rest_in  [ROOT_W];
    vec_t                 rt_vec_in   [ROOT_W];

    logic [QUOT_W-1:0]    dv_valid_reg;
    logic [2:0][DREM_W-1:0] dv_rem_reg  [QUOT_W];
    logic [2:0][QUOT_W-1:0] dv_quot_reg [QUOT_W];
    logic [2:0]           dv_neg_reg  [QUOT_W];
    logic [ROOT_W-1:0]    dv_len_reg  [QUOT_W];

    assign adv     = !out_valid_reg || pop;
    assign in_take = adv;
    assign empty   = !out_valid_reg;
    assign normal  = out_reg;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_root
            logic [REM_W+1:0]  r2;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  diff;
            logic              ge;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;
            logic [SUM_W-1:0]  rest_next;

            if (k == 0)
            begin : g_src
                assign rt_rem_in[k]  = '0;
                assign rt_root_in[k] = '0;
                assign rt_rest_in[k] = in_data.sum;
                assign rt_vec_in[k]  = in_data.vec;
            end
            else
            begin : g_src
                assign rt_rem_in[k]  = rt_rem_reg[k-1];
                assign rt_root_in[k] = rt_root_reg[k-1];
                assign rt_rest_in[k] = rt_rest_reg[k-1];
                assign rt_vec_in[k]  = rt_vec_reg[k-1];
            end

            assign r2        = {rt_rem_in[k], rt_rest_in[k][SUM_W-1 -: 2]};
            assign trial     = {2'b00, rt_root_in[k], 2'b01};
            assign ge        = (r2 >= trial);
            assign diff      = r2 - trial;
            assign rem_next  = ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
            assign root_next = {rt_root_in[k][ROOT_W-2:0], ge};
            assign rest_next = {rt_rest_in[k][SUM_W-3:0], 2'b00};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rt_rem_reg[k]  <= rem_next;
                    rt_root_reg[k] <= root_next;
                    rt_rest_reg[k] <= rest_next;
                    rt_vec_reg[k]  <= rt_vec_in[k];
                end
            end
        end

        for (k = 0; k < QUOT_W; k++)
        begin : g_div
            logic [2:0][DREM_W-1:0] rem_in;
            logic [2:0][QUOT_W-1:0] quot_in;
            logic [2:0]             neg_in;
            logic [ROOT_W-1:0]      len_in;
            logic [2:0][DREM_W-1:0] rem_next;
            logic [2:0][QUOT_W-1:0] quot_next;

            if (k == 0)
            begin : g_src
                assign len_in  = rt_root_reg[ROOT_W-1];
                assign neg_in  = rt_vec_reg[ROOT_W-1].neg;
                assign quot_in = '0;
                for (genvar c = 0; c < 3; c++)
                begin : g_c
                    assign rem_in[c] = DREM_W'(rt_vec_reg[ROOT_W-1].mag[c]);
                end
            end
            else
            begin : g_src
                assign len_in  = dv_len_reg[k-1];
                assign neg_in  = dv_neg_reg[k-1];
                assign quot_in = dv_quot_reg[k-1];
                assign rem_in  = dv_rem_reg[k-1];
            end

            always_comb
            begin
                logic [DREM_W-1:0] x;
                logic              ge;
                for (int c = 0; c < 3; c++)
                begin
                    x = (k == 0) ? rem_in[c] : {rem_in[c][DREM_W-2:0], 1'b0};
                    ge = (x >= DREM_W'(len_in));
                    rem_next[c]  = ge ? x - DREM_W'(len_in) : x;
                    quot_next[c] = {quot_in[c][QUOT_W-2:0], ge};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[k]  <= rem_next;
                    dv_quot_reg[k] <= quot_next;
                    dv_neg_reg[k]  <= neg_in;
                    dv_len_reg[k]  <= len_in;
                end
            end
        end
    endgenerate

    // zero length gives the zero vector and the flag
    always_comb
    begin
        logic              degen;
        logic [OUT_W-1:0]  q [3];
        logic [OUT_W-1:0]  n [3];
        degen = (dv_len_reg[QUOT_W-1] == '0);
        for (int c = 0; c < 3; c++)
        begin
            q[c] = OUT_W'(dv_quot_reg[QUOT_W-1][c]);
            n[c] = degen ? '0 : (dv_neg_reg[QUOT_W-1][c] ? -q[c] : q[c]);
        end
        out_next.nx         = n[0];
        out_next.ny         = n[1];
        out_next.nz         = n[2];
        out_next.degenerate = degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg  <= '0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rt_valid_reg  <= {rt_valid_reg[ROOT_W-2:0], in_valid};
            dv_valid_reg  <= {dv_valid_reg[QUOT_W-2:0], rt_valid_reg[ROOT_W-1]};
            out_valid_reg <= dv_valid_reg[QUOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/triangle_unit_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of one triangle per transfer, Q16.16 in, Q2.30 out.
//
//   channel   handshake      payload
//   input     push / full    vertices (tri_t)
//   result    pop / empty    normal (norm_t)
//
// one triangle per cycle sustained while full stays low and results are popped
// the square root pipeline has 66 steps and the divider pipeline 31 steps
// reset clears the valid bits and the queue pointers and count only
// a stalled result holds the back pipeline; the front keeps taking items
// until the middle queue fills
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal #(
    parameter int MID_DEPTH = tun_pkg::MID_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire tun_pkg::tri_t vertices,
    output logic               empty,
    input  wire logic          pop,
    output tun_pkg::norm_t     normal
);

    import tun_pkg::*;

    logic   fr_valid;
    logic   mid_full;
    cross_t fr_data;
    logic   mid_empty;
    logic   bk_take;
    cross_t mid_data;

    tun_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .vertices  (vertices),
        .out_valid (fr_valid),
        .out_full  (mid_full),
        .out_data  (fr_data)
    );

    tun_fifo #(
        .WIDTH ($bits(cross_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fr_valid),
        .full  (mid_full),
        .wdata (fr_data),
        .rd    (bk_take),
        .empty (mid_empty),
        .rdata (mid_data)
    );

    tun_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mid_empty),
        .in_take  (bk_take),
        .in_data  (mid_data),
        .empty    (empty),
        .pop      (pop),
        .normal   (normal)
    );

endmodule

`default_nettype wire

// ----- design/tun_checker.sv -----
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the triangle unit normal block.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           empty,
    input wire logic           pop,
    input wire tun_pkg::norm_t normal
);

    a_reset_empty : assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && normal.degenerate) |->
        (normal.nx == 0 && normal.ny == 0 && normal.nz == 0))
        else $error("degenerate result not zero");

    a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
        !empty |->
        (normal.nx <= 32'sd1073741824 && normal.nx >= -32'sd1073741824 &&
         normal.ny <= 32'sd1073741824 && normal.ny >= -32'sd1073741824 &&
         normal.nz <= 32'sd1073741824 && normal.nz >= -32'sd1073741824))
        else $error("normal component out of range");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(normal)))
        else $error("stalled result changed");

endmodule

bind triangle_unit_normal tun_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .normal   (normal)
);

`default_nettype wire
